// ===== design/kls_pkg.sv =====
// shared types and constants for the kth largest stream tracker
package kls_pkg;

    localparam int VALUE_W = 32;
    localparam int RANK_W  = 5;

    localparam logic OP_PRELOAD = 1'b0;
    localparam logic OP_ADD     = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0] kth_value;
        logic                      valid_res;
    } t_out_res;

    typedef struct packed {
        logic load_in;
        logic insert;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic op_add;
        logic out_free;
    } t_ctl_sts;

endpackage

// ===== design/kls_ctrl.sv =====
// sequencing state machine for request intake, insertion and result hand-off
module kls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kls_pkg::t_ctl_sts i_sts,
    output kls_pkg::t_ctl_cmd o_cmd
);
    import kls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_RES  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_INS;
                end
            end
            S_INS: begin
                o_cmd.insert = 1'b1;
                n_state      = i_sts.op_add ? S_RES : S_IDLE;
            end
            S_RES: begin
                // wait for the output register to drain
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/kls_dpath.sv =====
// sorted insertion row, rank register and result register
module kls_dpath #(
    parameter int MAX_K = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kls_pkg::t_in_req             i_in_req,
    input  logic                         i_cfg_we,
    input  logic [kls_pkg::RANK_W-1:0]   i_cfg_wdata,
    input  kls_pkg::t_ctl_cmd            i_cmd,
    output kls_pkg::t_ctl_sts            o_sts,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output kls_pkg::t_out_res            o_out_res
);
    import kls_pkg::*;

    localparam int CW   = $clog2(MAX_K + 1);
    localparam int CMPW = (CW > RANK_W) ? CW : RANK_W;
    localparam int IDX1 = (MAX_K > 1) ? 1 : 0;

    logic                      r_op;
    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] r_entry [MAX_K];
    logic [CW-1:0]             r_count;
    logic [RANK_W-1:0]         r_kth_rank;
    logic                      r_out_valid;
    t_out_res                  r_out;

    logic [MAX_K-1:0]          ge;
    logic [CMPW-1:0]           rank_ext;
    logic [CMPW-1:0]           count_ext;
    logic signed [VALUE_W-1:0] sel_val;
    t_out_res                  n_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op  <= i_in_req.operation;
            r_val <= i_in_req.value;
        end
    end

    // entry keeps its place while it is held and not smaller than the new value
    always_comb begin
        for (int i = 0; i < MAX_K; i++) begin
            ge[i] = (CW'(i) < r_count) && (r_entry[i] >= r_val);
        end
    end

    for (genvar gi = 0; gi < MAX_K; gi++) begin : g_row
        if (gi == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && !ge[gi]) begin
                    r_entry[gi] <= r_val;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (i_cmd.insert && !ge[gi]) begin
                    r_entry[gi] <= ge[gi-1] ? r_val : r_entry[gi-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert && (r_count < CW'(MAX_K))) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kth_rank <= RANK_W'(1);
        end else if (i_cfg_we) begin
            r_kth_rank <= i_cfg_wdata;
        end
    end

    // rank selection as an and-or over the row
    always_comb begin
        rank_ext  = CMPW'(r_kth_rank);
        count_ext = CMPW'(r_count);
        sel_val   = '0;
        for (int i = 0; i < MAX_K; i++) begin
            if (rank_ext == CMPW'(i + 1)) begin
                sel_val = sel_val | r_entry[i];
            end
        end
        n_out.valid_res = (r_kth_rank != '0) && (rank_ext <= CMPW'(MAX_K))
                          && (rank_ext <= count_ext);
        n_out.kth_value = n_out.valid_res ? sel_val : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.op_add   = (r_op == OP_ADD);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_res      = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_K))
        else $error("held count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert && (r_count < CW'(MAX_K)) |=> r_count == $past(r_count) + 1'b1)
        else $error("held count did not advance on insertion");

    a_row_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CW'(2)) |-> (r_entry[0] >= r_entry[IDX1]))
        else $error("head of row out of order");

    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_count != '0)
        else $error("row empty after insertion");

endmodule

// ===== design/kth_largest_stream_tracker_top.sv =====
// an add request is accepted from idle, inserted in the insert state and its result
// is registered in the result state once the output register is free
// a preload passes through idle and insert only; one request is in flight, so a new
// request is taken only once the last is back in idle; the result state waits on a stalled output
// the whole row is compared and shifted at once on insertion; the rank select is a mux
// reset clears the held count and output valid and sets the rank to one
module kth_largest_stream_tracker_top #(
    parameter int MAX_K = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  kls_pkg::t_in_req           i_in_req,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output kls_pkg::t_out_res          o_out_res,
    input  logic                       i_cfg_we,
    input  logic [kls_pkg::RANK_W-1:0] i_cfg_wdata
);
    import kls_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    kls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kls_dpath #(
        .MAX_K (MAX_K)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_req    (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res)
    );

endmodule
